>>> rtl/core/spq_pkg.sv
// Shared types, sizes and codes of the sorted priority queue.
`default_nettype none
package spq_pkg;

	localparam int unsigned QUEUE_DEPTH   = 16;
	localparam int unsigned PRIORITY_BITS = 8;
	localparam int unsigned PAYLOAD_BITS  = 16;
	localparam int unsigned FILL_BITS     = $clog2(QUEUE_DEPTH + 1);

	// Operation codes
	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_DEQUEUE = 1'b1;

	// Result status codes
	typedef enum logic [1:0] {
		STATUS_DONE  = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	// One held entry
	typedef struct packed {
		logic [PRIORITY_BITS-1:0] prio;
		logic [PAYLOAD_BITS-1:0]  payload;
	} entry_t;

	// Shift commands broadcast to every cell
	typedef struct packed {
		logic insert;   // accepted enqueue that fits
		logic remove;   // accepted dequeue on a non-empty queue
	} cell_ctl_t;

endpackage
`default_nettype wire

>>> rtl/core/spq_cell.sv
// One slot of the sorted chain: holds an entry, compares, shifts.
`default_nettype none
module spq_cell (
	input  wire                  clk,
	input  wire spq_pkg::cell_ctl_t ctl,
	input  wire spq_pkg::entry_t new_entry,
	input  wire spq_pkg::entry_t left_entry,
	input  wire                  left_keep,
	input  wire spq_pkg::entry_t right_entry,
	input  wire                  occupied,
	output spq_pkg::entry_t      entry_q,
	output logic                 keep
);
	import spq_pkg::*;

	// Entry stays put on insert when it is held and not behind the new one
	assign keep = occupied && (entry_q.prio <= new_entry.prio);

	// Insert: hold, take the new entry at the boundary, or shift right.
	// Remove: shift left.
	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			priority if (keep) begin
				entry_q <= entry_q;
			end else if (left_keep) begin
				entry_q <= new_entry;
			end else begin
				entry_q <= left_entry;
			end
		end else if (ctl.remove) begin
			entry_q <= right_entry;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/sorted_priority_queue.sv
// Top level of the sorted priority queue built as a chain of shift cells.
//
//  channel | beat                                  | handshake
//  --------+---------------------------------------+--------------------------
//  in      | operation, in_priority, in_payload    | in_valid / in_stall
//  out     | status, out_priority, out_payload,    | out_valid / out_stall
//          | fill_count                            |
//
// All cells compare against the new priority and shift in the same edge,
// so a beat can be accepted in each cycle while in_stall is low.
// The result sits in an output register; in_stall is high only while that
// register is full and out_stall holds it. arst_n empties the queue and
// the output register; the entry storage itself is not cleared.
`default_nettype none
module sorted_priority_queue (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire                                  operation,
	input  wire  [spq_pkg::PRIORITY_BITS-1:0]    in_priority,
	input  wire  [spq_pkg::PAYLOAD_BITS-1:0]     in_payload,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic [1:0]                           status,
	output logic [spq_pkg::PRIORITY_BITS-1:0]    out_priority,
	output logic [spq_pkg::PAYLOAD_BITS-1:0]     out_payload,
	output logic [spq_pkg::FILL_BITS-1:0]        fill_count
);
	import spq_pkg::*;

	logic [FILL_BITS-1:0]     count_q;
	logic                     out_valid_q;
	status_t                  status_q;
	logic [PRIORITY_BITS-1:0] out_prio_q;
	logic [PAYLOAD_BITS-1:0]  out_pay_q;
	logic [FILL_BITS-1:0]     fill_q;

	logic      accept;
	logic      is_full;
	logic      is_empty;
	cell_ctl_t ctl;
	entry_t    new_entry;
	entry_t    cell_entry [QUEUE_DEPTH];
	logic      cell_keep  [QUEUE_DEPTH];

	// Handshake: accept whenever the output register is free or draining
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	assign is_full  = (count_q == FILL_BITS'(QUEUE_DEPTH));
	assign is_empty = (count_q == '0);

	assign ctl.insert = accept && (operation == OP_ENQUEUE) && !is_full;
	assign ctl.remove = accept && (operation == OP_DEQUEUE) && !is_empty;

	assign new_entry.prio    = in_priority;
	assign new_entry.payload = in_payload;

	// Chain of cells, head at index 0
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t left_entry;
		logic   left_keep;
		entry_t right_entry;

		if (i == 0) begin : g_head
			assign left_entry = new_entry;
			assign left_keep  = 1'b1;
		end else begin : g_body
			assign left_entry = cell_entry[i-1];
			assign left_keep  = cell_keep[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_entry = cell_entry[i];
		end else begin : g_inner
			assign right_entry = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.new_entry   (new_entry),
			.left_entry  (left_entry),
			.left_keep   (left_keep),
			.right_entry (right_entry),
			.occupied    (FILL_BITS'(i) < count_q),
			.entry_q     (cell_entry[i]),
			.keep        (cell_keep[i])
		);
	end

	// Occupancy counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.insert) begin
			count_q <= count_q + FILL_BITS'(1);
		end else if (ctl.remove) begin
			count_q <= count_q - FILL_BITS'(1);
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output beat
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q   <= STATUS_DONE;
			out_prio_q <= '0;
			out_pay_q  <= '0;
			fill_q     <= count_q;
			unique case (operation)
				OP_ENQUEUE: begin
					if (is_full) begin
						status_q <= STATUS_FULL;
					end else begin
						fill_q <= count_q + FILL_BITS'(1);
					end
				end
				OP_DEQUEUE: begin
					if (is_empty) begin
						status_q <= STATUS_EMPTY;
					end else begin
						out_prio_q <= cell_entry[0].prio;
						out_pay_q  <= cell_entry[0].payload;
						fill_q     <= count_q - FILL_BITS'(1);
					end
				end
				default: begin
					status_q <= STATUS_DONE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_priority = out_prio_q;
	assign out_payload  = out_pay_q;
	assign fill_count   = fill_q;

endmodule
`default_nettype wire

>>> dv/sorted_priority_queue_tb.sv
// Self-checking testbench for the sorted priority queue: shadow queue, driver and monitor.
`timescale 1ns / 100ps
`default_nettype none
module sorted_priority_queue_tb;
	import spq_pkg::*;

	localparam int QUIET_LIMIT  = 2000;   // cycles with no beat on either side
	localparam int RANDOM_BEATS = 700;
	localparam int SHOWN_ERRORS = 10;

	// One queue command as it goes onto the input channel
	typedef struct {
		logic                     op;
		logic [PRIORITY_BITS-1:0] prio;
		logic [PAYLOAD_BITS-1:0]  payload;
		bit                       drain_first;   // hold until every owed result is back
	} cmd_beat_t;

	// One result beat
	typedef struct {
		status_t                  status;
		logic [PRIORITY_BITS-1:0] prio;
		logic [PAYLOAD_BITS-1:0]  payload;
		logic [FILL_BITS-1:0]     fill;
	} result_beat_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     operation = OP_ENQUEUE;
	logic [PRIORITY_BITS-1:0] in_priority = '0;
	logic [PAYLOAD_BITS-1:0]  in_payload = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [1:0]               status;
	logic [PRIORITY_BITS-1:0] out_priority;
	logic [PAYLOAD_BITS-1:0]  out_payload;
	logic [FILL_BITS-1:0]     fill_count;

	// Shadow copy of the sorted entries, head at index 0
	logic [PRIORITY_BITS-1:0] shadow_prio [QUEUE_DEPTH];
	logic [PAYLOAD_BITS-1:0]  shadow_payload [QUEUE_DEPTH];
	int                       shadow_fill = 0;

	cmd_beat_t    cmd_backlog[$];
	result_beat_t owed_results[$];
	cmd_beat_t    live_cmd;
	int           beats_sent = 0;
	int           total_beats = 0;
	int           gap_left = 0;
	int           stall_left = 0;
	int           mismatch_count = 0;
	int           quiet_cycles = 0;

	sorted_priority_queue dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.in_priority  (in_priority),
		.in_payload   (in_payload),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.out_priority (out_priority),
		.out_payload  (out_payload),
		.fill_count   (fill_count)
	);

	always #5 clk = ~clk;

	// Apply one command to the shadow queue and return the result it owes
	function automatic result_beat_t shadow_apply(cmd_beat_t c);
		result_beat_t r;
		int           pos;
		int           i;
		r.status  = STATUS_DONE;
		r.prio    = '0;
		r.payload = '0;
		if (c.op == OP_ENQUEUE) begin
			if (shadow_fill >= QUEUE_DEPTH) begin
				r.status = STATUS_FULL;
			end else begin
				// behind every entry of lower or equal priority
				pos = 0;
				while (pos < shadow_fill && shadow_prio[pos] <= c.prio)
					pos++;
				for (i = shadow_fill; i > pos; i--) begin
					shadow_prio[i]    = shadow_prio[i-1];
					shadow_payload[i] = shadow_payload[i-1];
				end
				shadow_prio[pos]    = c.prio;
				shadow_payload[pos] = c.payload;
				shadow_fill++;
			end
		end else begin
			if (shadow_fill == 0) begin
				r.status = STATUS_EMPTY;
			end else begin
				r.prio    = shadow_prio[0];
				r.payload = shadow_payload[0];
				for (i = 1; i < shadow_fill; i++) begin
					shadow_prio[i-1]    = shadow_prio[i];
					shadow_payload[i-1] = shadow_payload[i];
				end
				shadow_fill--;
			end
		end
		r.fill = shadow_fill[FILL_BITS-1:0];
		return r;
	endfunction

	task automatic add_cmd(logic op, logic [PRIORITY_BITS-1:0] prio,
			logic [PAYLOAD_BITS-1:0] payload, bit drain_first);
		cmd_beat_t c;
		c.op          = op;
		c.prio        = prio;
		c.payload     = payload;
		c.drain_first = drain_first;
		cmd_backlog.push_back(c);
	endtask

	// Driver: presents queued commands with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				owed_results.push_back(shadow_apply(live_cmd));
				beats_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (cmd_backlog.size() != 0 &&
						!(cmd_backlog[0].drain_first && owed_results.size() != 0)) begin
					live_cmd = cmd_backlog.pop_front();
					operation   <= live_cmd.op;
					in_priority <= live_cmd.prio;
					in_payload  <= live_cmd.payload;
					in_valid    <= 1'b1;
					gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random stalls, compares each result beat with the oldest owed one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (owed_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= SHOWN_ERRORS)
						$display("%0t: unexpected result st=%0d prio=%h pay=%h fill=%0d",
							$realtime, status, out_priority, out_payload, fill_count);
				end else if (status !== owed_results[0].status ||
						out_priority !== owed_results[0].prio ||
						out_payload !== owed_results[0].payload ||
						fill_count !== owed_results[0].fill) begin
					mismatch_count++;
					if (mismatch_count <= SHOWN_ERRORS)
						$display("%0t: result mismatch exp st=%0d prio=%h pay=%h fill=%0d %s",
							$realtime, owed_results[0].status, owed_results[0].prio,
							owed_results[0].payload, owed_results[0].fill,
							$sformatf("got st=%0d prio=%h pay=%h fill=%0d",
								status, out_priority, out_payload, fill_count));
				end
				if (owed_results.size() != 0)
					void'(owed_results.pop_front());
				stall_left = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
			end
			if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles == QUIET_LIMIT) begin
					$display("FAIL sorted_priority_queue");
					$finish;
				end
			end
		end
	end

	// Stimulus and end of run
	initial begin
		int                       i;
		int                       enq_pct;
		int                       seg_left;
		logic                     op;
		logic [PRIORITY_BITS-1:0] prio;

		// dequeue on empty, ignored fields all ones
		add_cmd(OP_DEQUEUE, '1, '1, 1'b0);
		// extremes and ties: equal priorities must leave in arrival order
		add_cmd(OP_ENQUEUE, 8'h80, 16'h0001, 1'b0);
		add_cmd(OP_ENQUEUE, 8'h00, 16'hFFFF, 1'b0);
		add_cmd(OP_ENQUEUE, 8'hFF, 16'h0000, 1'b0);
		add_cmd(OP_ENQUEUE, 8'h80, 16'h0002, 1'b0);
		add_cmd(OP_ENQUEUE, 8'h80, 16'h0003, 1'b0);
		add_cmd(OP_ENQUEUE, 8'h00, 16'h1234, 1'b0);
		add_cmd(OP_ENQUEUE, 8'hFF, 16'hABCD, 1'b0);
		for (i = 0; i < 9; i++)
			add_cmd(OP_ENQUEUE, (i % 3 == 0) ? 8'h55 : (i % 3 == 1) ? 8'hAA : 8'h80,
				16'h5A5A ^ 16'(i), 1'b0);
		// queue now full: this one is dropped
		add_cmd(OP_ENQUEUE, 8'h00, 16'hDEAD, 1'b0);
		for (i = 0; i < 3; i++)
			add_cmd(OP_DEQUEUE, PRIORITY_BITS'($urandom), PAYLOAD_BITS'($urandom), 1'b0);

		// random part in segments that lean toward filling, draining or mixing
		seg_left = 0;
		enq_pct  = 50;
		for (i = 0; i < RANDOM_BEATS; i++) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(10, 50);
				case ($urandom_range(0, 2))
					0: enq_pct = 15;
					1: enq_pct = 50;
					default: enq_pct = 85;
				endcase
			end
			seg_left--;
			op = ($urandom_range(1, 100) <= enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
			case ($urandom_range(0, 3))
				0: prio = PRIORITY_BITS'($urandom_range(0, 3));   // many ties
				1: prio = $urandom_range(0, 1) ? '1 : '0;
				default: prio = PRIORITY_BITS'($urandom);
			endcase
			add_cmd(op, prio, PAYLOAD_BITS'($urandom), i == 0 || $urandom_range(0, 99) == 0);
		end
		total_beats = cmd_backlog.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (beats_sent != total_beats)
			@(negedge clk);
		while (owed_results.size() != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS sorted_priority_queue");
		else
			$display("FAIL sorted_priority_queue");
		$finish;
	end

endmodule
`default_nettype wire

>>> sim.f
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue.sv
dv/sorted_priority_queue_tb.sv
